// ----- src/cpp_pkg.sv -----
// Shared types, constants and saturating arithmetic for the Chebyshev phase predictor.
// No dependencies.
`default_nettype none
package cpp_pkg;

  localparam int MAX_MODELS      = 8;
  localparam int MAX_TIME_COEFFS = 16;
  localparam int MAX_FREQ_COEFFS = 16;
  localparam int SEL_W  = $clog2(MAX_MODELS);
  localparam int TI_W   = $clog2(MAX_TIME_COEFFS);
  localparam int FI_W   = $clog2(MAX_FREQ_COEFFS);
  localparam int CADDR_W = SEL_W + FI_W + TI_W;
  localparam int CDEPTH  = MAX_MODELS * MAX_TIME_COEFFS * MAX_FREQ_COEFFS;

  localparam logic signed [31:0] ONE_Q30   = 32'sd1073741824;
  localparam logic signed [31:0] M_ONE_Q30 = -32'sd1073741824;
  localparam logic signed [63:0] PHASE_NOT_FOUND = -64'sd16777216;
  localparam logic signed [63:0] S64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] S64_MIN = 64'h8000_0000_0000_0000;

  typedef enum logic [1:0] {
    OP_WR_COEFF = 2'd0,
    OP_WR_TIME  = 2'd1,
    OP_WR_FREQ  = 2'd2,
    OP_QUERY    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    CFG_TIME_COUNT  = 2'd0,
    CFG_FREQ_COUNT  = 2'd1,
    CFG_MODEL_COUNT = 2'd2,
    CFG_NONE        = 2'd3
  } cfg_idx_t;

  typedef enum logic [4:0] {
    S_IDLE, S_SCAN_A, S_SCAN_B, S_SCAN_END, S_PREP, S_XSET, S_XDIV, S_YSET, S_YDIV,
    S_ROW_INIT, S_RD, S_RSTEP, S_RWAIT, S_C0RD, S_RFIN, S_RFWAIT, S_OUTER, S_OWAIT, S_OUT
  } state_t;

  typedef enum logic [2:0] {
    M_IDLE, M_LO, M_HI, M_ROUND, M_DBL, M_SUB, M_ADD
  } mac_step_t;

  typedef struct packed {
    logic              start;
    logic              dbl;
    logic signed [63:0] m;
    logic signed [31:0] q;
    logic signed [63:0] s;
    logic signed [63:0] a;
  } mac_req_t;

  typedef struct packed {
    logic              done;
    logic signed [63:0] res;
  } mac_rsp_t;

  typedef struct packed {
    logic        start;
    logic [63:0] num;
    logic [63:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [30:0] quo;
  } div_rsp_t;

  function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) return s[64] ? S64_MIN : S64_MAX;
    return s[63:0];
  endfunction

  function automatic logic signed [63:0] sat_sub(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} - {b[63], b};
    if (s[64] != s[63]) return s[64] ? S64_MIN : S64_MAX;
    return s[63:0];
  endfunction

  // divide by two, truncating toward zero
  function automatic logic signed [63:0] half(input logic signed [63:0] v);
    logic signed [63:0] s;
    s = v + {63'd0, v[63]};
    return s >>> 1;
  endfunction

endpackage
`default_nettype wire

// ----- src/cpp_if.sv -----
// Request and response channel interfaces of the phase predictor.
// No dependencies.
`default_nettype none
interface cpp_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         op;
  logic [2:0]         model_sel;
  logic [3:0]         time_idx;
  logic [3:0]         freq_idx;
  logic signed [63:0] coeff_value;
  logic [63:0]        range_low;
  logic [63:0]        range_high;
  logic [63:0]        query_mjd;
  logic [31:0]        query_freq;
  modport source(output valid, op, model_sel, time_idx, freq_idx, coeff_value, range_low,
                 range_high, query_mjd, query_freq, input ready);
  modport sink(input valid, op, model_sel, time_idx, freq_idx, coeff_value, range_low,
               range_high, query_mjd, query_freq, output ready);
endinterface

interface cpp_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] phase_value;
  logic               model_found;
  logic [2:0]         model_used;
  modport source(output valid, phase_value, model_found, model_used, input ready);
  modport sink(input valid, phase_value, model_found, model_used, output ready);
endinterface
`default_nettype wire

// ----- src/cpp_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module cpp_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ----- src/cpp_div.sv -----
// Restoring fractional divider, one quotient bit per cycle (31 bits).
// Depends on cpp_pkg.
`default_nettype none
module cpp_div import cpp_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire div_req_t req,
  output      div_rsp_t rsp
);
  logic        busy;
  logic [4:0]  cnt;
  logic [63:0] rem;
  logic [63:0] den;
  logic [30:0] quo;
  logic        done;
  logic [64:0] rem2;
  logic        take;

  assign rem2 = {rem, 1'b0};
  assign take = rem2 >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (!busy && req.start) begin
        busy <= 1'b1;
        cnt  <= 5'd30;
      end else if (busy) begin
        cnt <= cnt - 5'd1;
        if (cnt == 5'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!busy && req.start) begin
      rem <= req.num;
      den <= req.den;
      quo <= '0;
    end else if (busy) begin
      rem <= take ? (rem2[63:0] - den) : rem2[63:0];
      quo <= {quo[29:0], take};
    end
  end

  assign rsp.done = done;
  assign rsp.quo  = quo;
endmodule
`default_nettype wire

// ----- src/cpp_mac.sv -----
// Clenshaw step unit: rounded Q40.24 x Q1.30 multiply on one shared 32-bit
// multiplier, then optional saturating double, subtract and add. Depends on cpp_pkg.
`default_nettype none
module cpp_mac import cpp_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire mac_req_t req,
  output      mac_rsp_t rsp
);
  mac_step_t step, step_next;
  logic               neg;
  logic               dbl;
  logic [63:0]        ud;
  logic [30:0]        ux;
  logic signed [63:0] sub_op;
  logic signed [63:0] add_op;
  logic [62:0]        plo;
  logic [62:0]        phi;
  logic signed [63:0] acc;
  logic               done;
  logic [31:0]        mop;
  logic [62:0]        prod;
  logic [63:0]        lo_rnd;
  logic [64:0]        mag;
  logic signed [63:0] rnd;

  assign mop    = (step == M_LO) ? ud[31:0] : ud[63:32];
  assign prod   = mop * ux;
  assign lo_rnd = {1'b0, plo} + 64'd536870912;
  assign mag    = {phi, 2'b00} + {31'd0, lo_rnd[63:30]};

  always_comb begin
    if (neg) begin
      rnd = (mag >= 65'h0_8000_0000_0000_0000) ? S64_MIN : -$signed(mag[63:0]);
    end else begin
      rnd = (mag > 65'h0_7FFF_FFFF_FFFF_FFFF) ? S64_MAX : $signed(mag[63:0]);
    end
  end

  always_comb begin
    step_next = step;
    unique case (step)
      M_IDLE:  if (req.start) step_next = M_LO;
      M_LO:    step_next = M_HI;
      M_HI:    step_next = M_ROUND;
      M_ROUND: step_next = M_DBL;
      M_DBL:   step_next = M_SUB;
      M_SUB:   step_next = M_ADD;
      M_ADD:   step_next = M_IDLE;
      default: step_next = M_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= M_IDLE;
      done <= 1'b0;
    end else begin
      step <= step_next;
      done <= (step == M_ADD);
    end
  end

  always_ff @(posedge clk) begin
    case (step)
      M_IDLE: begin
        neg    <= req.m[63] ^ req.q[31];
        ud     <= req.m[63] ? (64'd0 - req.m) : req.m;
        ux     <= req.q[31] ? 31'(32'd0 - req.q) : req.q[30:0];
        dbl    <= req.dbl;
        sub_op <= req.s;
        add_op <= req.a;
      end
      M_LO:    plo <= prod;
      M_HI:    phi <= prod;
      M_ROUND: acc <= rnd;
      M_DBL:   acc <= dbl ? sat_add(acc, acc) : acc;
      M_SUB:   acc <= sat_sub(acc, sub_op);
      M_ADD:   acc <= sat_add(acc, add_op);
      default: acc <= acc;
    endcase
  end

  assign rsp.done = done;
  assign rsp.res  = acc;
endmodule
`default_nettype wire

// ----- src/chebyshev_phase_predictor_unit.sv -----
// Chebyshev phase predictor: write requests are taken one a cycle while idle; a query
// scans the models, runs up to two divisions and the Clenshaw recurrence on one shared
// multiply unit. One request at a time; not ready until the result is registered.
// Synchronous reset clears control and the model count and sets the time and frequency
// counts to 1; stores are undefined until written.
`default_nettype none
module chebyshev_phase_predictor_unit import cpp_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [4:0] cfg_data,
  cpp_req_if.sink         req,
  cpp_rsp_if.source       rsp
);
  state_t state, state_next;

  logic [4:0] tcc, fcc;
  logic [3:0] mcnt;
  logic [4:0] nx, ny;
  logic [3:0] nmod;

  logic [63:0] tstart [MAX_MODELS];
  logic [63:0] tend   [MAX_MODELS];
  logic [31:0] fstart [MAX_MODELS];
  logic [31:0] fend   [MAX_MODELS];

  logic [63:0] qmjd;
  logic [31:0] qfreq;
  logic [3:0]  sidx;
  logic [SEL_W-1:0] best, rsel;
  logic        found, scov;
  logic [63:0] best_off, sa, sb, off;
  logic [63:0] pa, pw;
  logic signed [32:0] fnum, fden, n0, d0;
  logic signed [31:0] xq, yq;
  logic [TI_W-1:0] ci;
  logic [FI_W-1:0] cj;
  logic signed [63:0] rd, rd1, od, od1, rowv, phase;
  logic [63:0] cur_ts, cur_te;
  logic [31:0] cur_fs, cur_fe;

  logic        acc_in;
  logic        rsp_valid;
  logic        rsp_load;
  logic [63:0] ram_rdata;
  mac_req_t    mreq;
  mac_rsp_t    mrsp;
  div_req_t    dreq;
  div_rsp_t    drsp;

  assign nx   = (tcc == 5'd0) ? 5'd1 : ((tcc > 5'(MAX_TIME_COEFFS)) ? 5'(MAX_TIME_COEFFS) : tcc);
  assign ny   = (fcc == 5'd0) ? 5'd1 : ((fcc > 5'(MAX_FREQ_COEFFS)) ? 5'(MAX_FREQ_COEFFS) : fcc);
  assign nmod = (mcnt > 4'(MAX_MODELS)) ? 4'(MAX_MODELS) : mcnt;

  assign rsel   = (state == S_SCAN_A) ? sidx[SEL_W-1:0] : best;
  assign cur_ts = tstart[rsel];
  assign cur_te = tend[rsel];
  assign cur_fs = fstart[rsel];
  assign cur_fe = fend[rsel];
  assign off    = (sb >= sa) ? (sb - sa) : (sa - sb);
  assign n0     = $signed({1'b0, qfreq}) - $signed({1'b0, cur_fs});
  assign d0     = $signed({1'b0, cur_fe}) - $signed({1'b0, cur_fs});

  assign acc_in   = req.valid && req.ready;
  assign rsp_load = (state == S_OUT) && (!rsp_valid || rsp.ready);

  cpp_ram #(.WIDTH(64), .DEPTH(CDEPTH)) u_coeff (
    .clk   (clk),
    .we    (acc_in && (req.op != OP_QUERY) && (req.op == OP_WR_COEFF)),
    .waddr ({req.model_sel, req.freq_idx, req.time_idx}),
    .wdata (req.coeff_value),
    .raddr ({best, cj, ci}),
    .rdata (ram_rdata)
  );

  cpp_mac u_mac (.clk(clk), .rst(rst), .req(mreq), .rsp(mrsp));
  cpp_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:
        if (acc_in && req.op == OP_QUERY) state_next = (nmod == 4'd0) ? S_SCAN_END : S_SCAN_A;
      S_SCAN_A:   state_next = S_SCAN_B;
      S_SCAN_B:   state_next = (sidx + 4'd1 == nmod) ? S_SCAN_END : S_SCAN_A;
      S_SCAN_END: state_next = found ? S_PREP : S_OUT;
      S_PREP:     state_next = S_XSET;
      S_XSET:     state_next = (pw == 64'd0 || pa >= pw) ? S_YSET : S_XDIV;
      S_XDIV:     if (drsp.done) state_next = S_YSET;
      S_YSET:
        state_next = (fden == 33'sd0 || fnum <= 33'sd0 || fnum >= fden) ? S_ROW_INIT : S_YDIV;
      S_YDIV:     if (drsp.done) state_next = S_ROW_INIT;
      S_ROW_INIT: state_next = (nx == 5'd1) ? S_C0RD : S_RD;
      S_RD:       state_next = S_RSTEP;
      S_RSTEP:    state_next = S_RWAIT;
      S_RWAIT:    if (mrsp.done) state_next = (ci == TI_W'(1)) ? S_C0RD : S_RD;
      S_C0RD:     state_next = S_RFIN;
      S_RFIN:     state_next = S_RFWAIT;
      S_RFWAIT:   if (mrsp.done) state_next = S_OUTER;
      S_OUTER:    state_next = S_OWAIT;
      S_OWAIT:    if (mrsp.done) state_next = (cj == '0) ? S_OUT : S_ROW_INIT;
      S_OUT:      if (rsp_load) state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  always_comb begin
    req.ready  = 1'b0;
    mreq       = '0;
    dreq       = '0;
    mreq.q     = xq;
    mreq.m     = rd;
    mreq.s     = rd1;
    dreq.num   = pa;
    dreq.den   = pw;
    unique case (state)
      S_IDLE:  req.ready = 1'b1;
      S_XSET:  dreq.start = !(pw == 64'd0 || pa >= pw);
      S_YSET: begin
        dreq.start = !(fden == 33'sd0 || fnum <= 33'sd0 || fnum >= fden);
        dreq.num   = {32'd0, fnum[31:0]};
        dreq.den   = {32'd0, fden[31:0]};
      end
      S_RSTEP: begin
        mreq.start = 1'b1;
        mreq.dbl   = 1'b1;
        mreq.a     = $signed(ram_rdata);
      end
      S_RFIN: begin
        mreq.start = 1'b1;
        mreq.a     = half($signed(ram_rdata));
      end
      S_OUTER: begin
        mreq.start = 1'b1;
        mreq.q     = yq;
        mreq.m     = od;
        mreq.s     = od1;
        mreq.dbl   = (cj != '0);
        mreq.a     = (cj != '0) ? rowv : half(rowv);
      end
      default: req.ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      tcc       <= 5'd1;
      fcc       <= 5'd1;
      mcnt      <= 4'd0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_TIME_COUNT:  tcc  <= cfg_data;
          CFG_FREQ_COUNT:  fcc  <= cfg_data;
          CFG_MODEL_COUNT: mcnt <= cfg_data[3:0];
          default:         mcnt <= mcnt;
        endcase
      end
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc_in) begin
      if (req.op == OP_WR_TIME) begin
        tstart[req.model_sel] <= req.range_low;
        tend[req.model_sel]   <= req.range_high;
      end
      if (req.op == OP_WR_FREQ) begin
        fstart[req.model_sel] <= req.range_low[31:0];
        fend[req.model_sel]   <= req.range_high[31:0];
      end
      qmjd  <= req.query_mjd;
      qfreq <= req.query_freq;
      sidx  <= '0;
      found <= 1'b0;
      best  <= '0;
    end
    unique case (state)
      S_SCAN_A: begin
        scov <= (qmjd >= cur_ts) && (qmjd <= cur_te);
        sa   <= qmjd - cur_ts;
        sb   <= cur_te - qmjd;
      end
      S_SCAN_B: begin
        if (scov && (!found || off < best_off)) begin
          found    <= 1'b1;
          best_off <= off;
          best     <= sidx[SEL_W-1:0];
        end
        sidx <= sidx + 4'd1;
      end
      S_SCAN_END: phase <= PHASE_NOT_FOUND;
      S_PREP: begin
        pa   <= qmjd - cur_ts;
        pw   <= cur_te - cur_ts;
        fnum <= d0[32] ? -n0 : n0;
        fden <= d0[32] ? -d0 : d0;
      end
      S_XSET: begin
        if (pw == 64'd0) xq <= M_ONE_Q30;
        else if (pa >= pw) xq <= ONE_Q30;
      end
      S_XDIV: if (drsp.done) xq <= $signed({1'b0, drsp.quo}) - ONE_Q30;
      S_YSET: begin
        if (fden == 33'sd0) yq <= (fnum > 33'sd0) ? ONE_Q30 : M_ONE_Q30;
        else if (fnum <= 33'sd0) yq <= M_ONE_Q30;
        else if (fnum >= fden) yq <= ONE_Q30;
        od  <= '0;
        od1 <= '0;
        cj  <= FI_W'(ny - 5'd1);
      end
      S_YDIV: if (drsp.done) yq <= $signed({1'b0, drsp.quo}) - ONE_Q30;
      S_ROW_INIT: begin
        rd  <= '0;
        rd1 <= '0;
        ci  <= TI_W'(nx - 5'd1);
      end
      S_RSTEP: rd1 <= rd;
      S_RWAIT: begin
        if (mrsp.done) begin
          rd <= mrsp.res;
          ci <= ci - TI_W'(1);
        end
      end
      S_RFWAIT: if (mrsp.done) rowv <= mrsp.res;
      S_OUTER: if (cj != '0) od1 <= od;
      S_OWAIT: begin
        if (mrsp.done) begin
          if (cj == '0) begin
            phase <= mrsp.res;
          end else begin
            od <= mrsp.res;
            cj <= cj - FI_W'(1);
          end
        end
      end
      default: begin
      end
    endcase
    if (rsp_load) begin
      rsp.phase_value <= phase;
      rsp.model_found <= found;
      rsp.model_used  <= found ? best : '0;
    end
  end

  assign rsp.valid = rsp_valid;

  a_not_found: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.model_found |-> rsp.phase_value == PHASE_NOT_FOUND && rsp.model_used == '0)
    else $error("not-found result carries wrong payload");

  a_busy_after_query: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready && req.op == OP_QUERY |=> !req.ready)
    else $error("ready right after a query request");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN_A |-> sidx < nmod)
    else $error("model scan ran past model count");
endmodule
`default_nettype wire
